@@ src/dem_pkg.sv @@
// ----------------------------------------------------------------------------
// dem_pkg
// shared types and constants for the directional edge magnitude pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package dem_pkg;

   localparam int NUM_DIRS       = 8;
   localparam int MAG_WIDTH      = 17;
   localparam int RSP_DATA_WIDTH = 24;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [MAG_WIDTH-1:0] MAG_MAX = {MAG_WIDTH{1'b1}};

   // register indexes, taken from csr address bit 2
   localparam logic REG_SELECT_MODE    = 1'b0;
   localparam logic REG_DIRECTION_MASK = 1'b1;

   typedef struct packed {
      logic                select_mode;
      logic [NUM_DIRS-1:0] direction_mask;
   } cfg_type;

endpackage

`default_nettype wire

@@ src/dem_square.sv @@
// ----------------------------------------------------------------------------
// dem_square
// two stage front end: gated absolute value, then per-direction square
// ----------------------------------------------------------------------------
`default_nettype none

module dem_square #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                               clock,
   input  wire                                               reset,
   input  dem_pkg::cfg_type                                  cfg,
   input  wire                                               in_valid,
   output logic                                              in_ready,
   input  wire [dem_pkg::NUM_DIRS-1:0][SAMPLE_WIDTH-1:0]     in_resp,
   input  wire                                               in_last,
   output logic                                              out_valid,
   input  wire                                               out_ready,
   output logic [dem_pkg::NUM_DIRS-1:0][2*SAMPLE_WIDTH-2:0]  out_sq,
   output logic                                              out_last
);

   localparam int SQW = 2*SAMPLE_WIDTH-1;

   logic                                          valid0_ff;
   logic                                          valid1_ff;
   logic                                          ready0;
   logic                                          ready1;
   logic [dem_pkg::NUM_DIRS-1:0][SAMPLE_WIDTH-1:0] abs_in;
   logic [dem_pkg::NUM_DIRS-1:0][SAMPLE_WIDTH-1:0] abs_ff;
   logic [dem_pkg::NUM_DIRS-1:0][SQW-1:0]          sq_in;
   logic [dem_pkg::NUM_DIRS-1:0][SQW-1:0]          sq_ff;
   logic                                          last0_ff;
   logic                                          last1_ff;

   assign ready1   = !valid1_ff || out_ready;
   assign ready0   = !valid0_ff || ready1;
   assign in_ready = ready0;

   // directions left out in selected mode contribute zero
   always_comb begin
      for (int k = 0; k < dem_pkg::NUM_DIRS; k++) begin
         if (!cfg.select_mode || cfg.direction_mask[k]) begin
            abs_in[k] = in_resp[k][SAMPLE_WIDTH-1] ? (~in_resp[k] + 1'b1) : in_resp[k];
         end else begin
            abs_in[k] = '0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < dem_pkg::NUM_DIRS; k++) begin
         sq_in[k] = SQW'(abs_ff[k]) * SQW'(abs_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
         valid1_ff <= 1'b0;
      end else begin
         if (ready0) begin
            valid0_ff <= in_valid;
         end
         if (ready1) begin
            valid1_ff <= valid0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready0) begin
         abs_ff   <= abs_in;
         last0_ff <= in_last;
      end
      if (ready1) begin
         sq_ff    <= sq_in;
         last1_ff <= last0_ff;
      end
   end

   assign out_valid = valid1_ff;
   assign out_sq    = sq_ff;
   assign out_last  = last1_ff;

endmodule

`default_nettype wire

@@ src/dem_sum.sv @@
// ----------------------------------------------------------------------------
// dem_sum
// three stage registered adder tree over the eight squares
// ----------------------------------------------------------------------------
`default_nettype none

module dem_sum #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                               clock,
   input  wire                                               reset,
   input  wire                                               in_valid,
   output logic                                              in_ready,
   input  wire [dem_pkg::NUM_DIRS-1:0][2*SAMPLE_WIDTH-2:0]   in_sq,
   input  wire                                               in_last,
   output logic                                              out_valid,
   input  wire                                               out_ready,
   output logic [2*SAMPLE_WIDTH+1:0]                         out_sum,
   output logic                                              out_last
);

   localparam int SUMW = 2*SAMPLE_WIDTH+2;

   logic [2:0]           valid_ff;
   logic [3:0]           ready;
   logic [2:0]           last_ff;
   logic [3:0][SUMW-1:0] quad_in;
   logic [3:0][SUMW-1:0] quad_ff;
   logic [1:0][SUMW-1:0] pair_in;
   logic [1:0][SUMW-1:0] pair_ff;
   logic [SUMW-1:0]      total_in;
   logic [SUMW-1:0]      total_ff;

   assign ready[3] = out_ready;
   assign ready[2] = !valid_ff[2] || ready[3];
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];
   assign in_ready = ready[0];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         quad_in[k] = SUMW'(in_sq[2*k]) + SUMW'(in_sq[2*k+1]);
      end
      for (int k = 0; k < 2; k++) begin
         pair_in[k] = quad_ff[2*k] + quad_ff[2*k+1];
      end
      total_in = pair_ff[0] + pair_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= in_valid;
         if (ready[1]) valid_ff[1] <= valid_ff[0];
         if (ready[2]) valid_ff[2] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         quad_ff    <= quad_in;
         last_ff[0] <= in_last;
      end
      if (ready[1]) begin
         pair_ff    <= pair_in;
         last_ff[1] <= last_ff[0];
      end
      if (ready[2]) begin
         total_ff   <= total_in;
         last_ff[2] <= last_ff[1];
      end
   end

   assign out_valid = valid_ff[2];
   assign out_sum   = total_ff;
   assign out_last  = last_ff[2];

endmodule

`default_nettype wire

@@ src/dem_sqrt.sv @@
// ----------------------------------------------------------------------------
// dem_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module dem_sqrt #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire [2*SAMPLE_WIDTH+1:0]     in_sum,
   input  wire                          in_last,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [SAMPLE_WIDTH:0]        out_root,
   output logic                         out_last
);

   localparam int SUMW = 2*SAMPLE_WIDTH+2;
   localparam int RW   = SAMPLE_WIDTH+1;

   logic [RW-1:0]            valid_ff;
   logic [RW:0]              ready;
   logic [RW-1:0]            last_ff;
   logic [RW-1:0][SUMW-1:0]  rem_ff;
   logic [RW-1:0][SUMW-1:0]  root_ff;

   assign ready[RW] = out_ready;
   assign in_ready  = ready[0];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      localparam logic [SUMW-1:0] BIT = SUMW'(1) << (2*(RW-1-i));

      logic            valid_src;
      logic            last_src;
      logic [SUMW-1:0] rem_src;
      logic [SUMW-1:0] root_src;
      logic [SUMW-1:0] trial;
      logic [SUMW-1:0] rem_in;
      logic [SUMW-1:0] root_in;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign last_src  = in_last;
         assign rem_src   = in_sum;
         assign root_src  = '0;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign last_src  = last_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign root_src  = root_ff[i-1];
      end

      assign ready[i] = !valid_ff[i] || ready[i+1];
      assign trial    = root_src + BIT;

      always_comb begin
         if (rem_src >= trial) begin
            rem_in  = rem_src - trial;
            root_in = (root_src >> 1) + BIT;
         end else begin
            rem_in  = rem_src;
            root_in = root_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[i]) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            last_ff[i] <= last_src;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1][RW-1:0];
   assign out_last  = last_ff[RW-1];

endmodule

`default_nettype wire

@@ src/directional_edge_magnitude.sv @@
// ----------------------------------------------------------------------------
// directional_edge_magnitude
// eight-direction gradient magnitude: floor(sqrt(sum of squared responses))
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the result side accepts: eight signed
// directional responses plus a last-pixel mark, and returns one transaction
// per pixel holding the floor square root of the sum of the squared
// responses (saturated at 17 bits). In all-direction mode (select_mode = 0)
// every response is summed; in selected mode only directions whose
// direction_mask bit is set. The pipeline is fully streaming, one pixel per
// cycle sustained unless the result side stalls. Its stages are absolute
// value and squaring, the adder tree, the square root pipeline, and the
// output register. Every stage has its own valid bit and holds only when
// the stage after it is full and stalled, so bubbles collapse and input is
// taken while a result waits at the output. Registers: select_mode at byte
// address 0 (reset 0), direction_mask at byte address 4 (reset 0xff); the
// user must write both only while the pipeline is empty, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_edge_magnitude #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input pixel transaction
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // resp_0, resp_45, resp_90, resp_135, resp_180, resp_225, resp_270, resp_315
   input  wire [8*SAMPLE_WIDTH-1:0]             req_tdata,
   input  wire                                  req_tlast,   // last_in
   // result transaction
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // magnitude, then zero fill
   output logic [dem_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,   // last_out
   // register port
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [dem_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire [dem_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [dem_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int SQW  = 2*SAMPLE_WIDTH-1;
   localparam int SUMW = 2*SAMPLE_WIDTH+2;
   localparam int RW   = SAMPLE_WIDTH+1;

   // configuration registers
   logic                           select_mode_ff;
   logic [dem_pkg::NUM_DIRS-1:0]   direction_mask_ff;
   logic                           csr_write;
   logic                           csr_index;
   dem_pkg::cfg_type               cfg;

   // inter-stage handshakes
   logic                                          sq_valid;
   logic                                          sq_ready;
   logic [dem_pkg::NUM_DIRS-1:0][SQW-1:0]          sq_data;
   logic                                          sq_last;
   logic                                          sum_valid;
   logic                                          sum_ready;
   logic [SUMW-1:0]                               sum_data;
   logic                                          sum_last;
   logic                                          root_valid;
   logic                                          root_ready;
   logic [RW-1:0]                                 root_data;
   logic                                          root_last;

   // output register
   logic                                          rsp_valid_ff;
   logic [dem_pkg::MAG_WIDTH-1:0]                 mag_in;
   logic [dem_pkg::MAG_WIDTH-1:0]                 mag_ff;
   logic                                          last_ff;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         select_mode_ff    <= 1'b0;
         direction_mask_ff <= '1;
      end else if (csr_write) begin
         case (csr_index)
            dem_pkg::REG_SELECT_MODE:    select_mode_ff    <= csr_pwdata[0];
            dem_pkg::REG_DIRECTION_MASK: direction_mask_ff <= csr_pwdata[dem_pkg::NUM_DIRS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dem_pkg::REG_SELECT_MODE:
            csr_prdata = dem_pkg::CSR_DATA_WIDTH'(select_mode_ff);
         dem_pkg::REG_DIRECTION_MASK:
            csr_prdata = dem_pkg::CSR_DATA_WIDTH'(direction_mask_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.select_mode    = select_mode_ff;
   assign cfg.direction_mask = direction_mask_ff;

   // ---------------------------------------------------------------- datapath
   // abs and square, two stages
   dem_square #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_resp   (req_tdata),
      .in_last   (req_tlast),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_sq    (sq_data),
      .out_last  (sq_last)
   );

   // 8 -> 4 -> 2 -> 1 adder tree, three stages
   dem_sum #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_sq     (sq_data),
      .in_last   (sq_last),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum_data),
      .out_last  (sum_last)
   );

   // one root bit per stage
   dem_sqrt #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sum_data),
      .in_last   (sum_last),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_root  (root_data),
      .out_last  (root_last)
   );

   // saturate to the 17-bit result field; only wide samples can reach it
   always_comb begin
      if (RW > dem_pkg::MAG_WIDTH && root_data > RW'(dem_pkg::MAG_MAX)) begin
         mag_in = dem_pkg::MAG_MAX;
      end else begin
         mag_in = dem_pkg::MAG_WIDTH'(root_data);
      end
   end

   // output register parts the pipeline from the result side
   assign root_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (root_ready) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (root_ready) begin
         mag_ff  <= mag_in;
         last_ff <= root_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dem_pkg::RSP_DATA_WIDTH'(mag_ff);
   assign rsp_tlast  = last_ff;

   // ---------------------------------------------------------------- checks
   // an empty output register means every stage can advance
   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with an empty output register");

   // a mask write lands in the register on the next cycle
   a_mask_write : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(csr_write) &&
       $past(csr_index) == dem_pkg::REG_DIRECTION_MASK)
      |-> direction_mask_ff == $past(csr_pwdata[dem_pkg::NUM_DIRS-1:0]))
      else $error("direction mask write lost");

   // nothing comes out right after reset
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented right after reset");

   // a stalled result never loses its pixel mark or value
   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid_ff) && !$past(rsp_tready))
      |-> rsp_valid_ff && mag_ff == $past(mag_ff) && last_ff == $past(last_ff))
      else $error("output register changed under stall");

endmodule

`default_nettype wire
